FILE: rtl/assert_macros.svh
// Assertion wrappers for the glyph atlas shelf packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GASP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gasp assertion failed");
`define GASP_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gasp assertion failed");
`else
`define GASP_ASSERT(lbl, clk, rst, prop)
`define GASP_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: rtl/gasp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gasp_pkg;

   localparam int START_SIZE_DEF = 256;
   localparam int GROW_BOUND_DEF = 10;
   localparam int GROW_LIMIT_RST = 10;

   localparam int SIZE_CAP = 16384;
   localparam int POS_MAX  = 16383;

   localparam int GLYPH_W  = 12;
   localparam int POS_W    = 14;
   localparam int DIM_W    = 15;
   localparam int GROW_W   = 4;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   typedef struct packed {
      logic capture;
      logic place;
      logic grow;
      logic new_row;
      logic fail;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic failed;
      logic fit;
      logic need_grow;
      logic grow_ok;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/glyph_atlas_shelf_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Ports                  Contents
// req      in   req_tvalid/tready      tuser: new_font; tdata: glyph size
// rsp      out  rsp_tvalid/tready      tuser: placed; tdata: position, atlas size
// csr      in   csr_wr_en/csr_wr_data  grow_limit
//
// One transaction at a time: an accept step in the idle state, then one fit/grow/new-row
// decision per cycle in the datapath step loop, then a load of the output register.
// Steps per glyph: at most one new row, one per applied grow, one to place or fail,
// so 1 to 12 steps per transaction.
// The next transaction is accepted while a result waits in the output register;
// a second result holds in the output state until the first is taken.
// Reset is synchronous, active high; no clearing pass.
module glyph_atlas_shelf_packer #(
   parameter int START_SIZE = gasp_pkg::START_SIZE_DEF,
   parameter int GROW_BOUND = gasp_pkg::GROW_BOUND_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // [11:0] glyph_width, [23:12] glyph_height
   input  wire  [gasp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] new_font
   input  wire                              req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // [13:0] pos_x, [27:14] pos_y, [42:28] atlas_width_now,
   // [57:43] atlas_height_now, [63:58] zero
   output logic [gasp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] placed
   output logic                             rsp_tuser,
   input  wire                              csr_wr_en,
   input  wire  [gasp_pkg::GROW_W-1:0]      csr_wr_data
);
   import gasp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   gasp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   gasp_dpath #(
      .START_SIZE (START_SIZE),
      .GROW_BOUND (GROW_BOUND)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .st          (st),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: rtl/gasp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gasp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   input  gasp_pkg::dp_status_type st,
   output gasp_pkg::dp_cmd_type   cmd
);
   import gasp_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_STEP = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_STEP;
            end
         end
         S_STEP: begin
            priority if (st.failed) begin
               cmd.fail = 1'b1;
               state_in = S_OUT;
            end else if (st.fit) begin
               cmd.place = 1'b1;
               state_in  = S_OUT;
            end else if (st.need_grow) begin
               cmd.grow = 1'b1;
               if (!st.grow_ok) begin
                  cmd.fail = 1'b1;
                  state_in = S_OUT;
               end
            end else begin
               cmd.new_row = 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   `GASP_ASSERT(a_accept_to_step, clock, reset, (state_ff == S_IDLE && req_tvalid) |=> state_ff == S_STEP)
   `GASP_ASSERT(a_load_sets_valid, clock, reset, cmd.load_out |=> rsp_tvalid_ff)
   `GASP_ASSERT_NR(a_valid_from_out, clock, $rose(rsp_tvalid_ff) |-> $past(state_ff == S_OUT))

endmodule
`default_nettype wire

FILE: rtl/gasp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gasp_dpath #(
   parameter int START_SIZE = gasp_pkg::START_SIZE_DEF,
   parameter int GROW_BOUND = gasp_pkg::GROW_BOUND_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [gasp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                 req_tuser,
   input  wire                                 csr_wr_en,
   input  wire  [gasp_pkg::GROW_W-1:0]         csr_wr_data,
   input  gasp_pkg::dp_cmd_type                cmd,
   output gasp_pkg::dp_status_type             st,
   output logic [gasp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);
   import gasp_pkg::*;

   localparam logic [DIM_W-1:0]  START_V  = DIM_W'(START_SIZE);
   localparam logic [DIM_W-1:0]  HALF_CAP = DIM_W'(SIZE_CAP / 2);
   localparam logic [DIM_W-1:0]  CAP_V    = DIM_W'(SIZE_CAP);
   localparam logic [DIM_W-1:0]  POS_MAXV = DIM_W'(POS_MAX);
   localparam logic [GROW_W-1:0] BOUND_V  = GROW_W'(GROW_BOUND);
   localparam logic [GROW_W-1:0] GROW_SAT = '1;

   logic [GROW_W-1:0]  limit_ff;
   logic [GLYPH_W-1:0] w_ff, h_ff;
   logic [DIM_W-1:0]   cur_x_ff, cur_y_ff, row_x_ff, width_ff, height_ff;
   logic [GLYPH_W-1:0] row_h_ff;
   logic [GROW_W-1:0]  grows_ff;
   logic               failed_ff;
   logic               res_placed_ff;
   logic [POS_W-1:0]   res_x_ff, res_y_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic               rsp_tuser_ff;

   logic [DIM_W-1:0]   mx, my, dim;
   logic [GROW_W-1:0]  lim, grow_n;
   logic               to_right, capped;

   always_comb begin
      mx       = cur_x_ff + DIM_W'(w_ff);
      my       = cur_y_ff + DIM_W'(h_ff);
      lim      = (limit_ff < BOUND_V) ? limit_ff : BOUND_V;
      grow_n   = (grows_ff == GROW_SAT) ? GROW_SAT : grows_ff + GROW_W'(1);
      to_right = ~grows_ff[0];
      dim      = to_right ? width_ff : height_ff;
      capped   = dim > HALF_CAP;
      st.failed    = failed_ff;
      st.fit       = (mx <= width_ff) && (my <= height_ff);
      st.need_grow = (my > height_ff) || (cur_x_ff == row_x_ff);
      st.grow_ok   = !capped && (grow_n <= lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= GROW_W'(GROW_LIMIT_RST);
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         row_x_ff  <= '0;
         row_h_ff  <= '0;
         width_ff  <= START_V;
         height_ff <= START_V;
         grows_ff  <= '0;
         failed_ff <= 1'b0;
      end else if (cmd.capture) begin
         if (req_tuser) begin
            cur_x_ff  <= '0;
            cur_y_ff  <= '0;
            row_x_ff  <= '0;
            row_h_ff  <= '0;
            width_ff  <= START_V;
            height_ff <= START_V;
            grows_ff  <= '0;
            failed_ff <= 1'b0;
         end
      end else begin
         if (cmd.place) begin
            cur_x_ff <= mx;
            if (h_ff > row_h_ff) begin
               row_h_ff <= h_ff;
            end
         end
         if (cmd.new_row) begin
            cur_y_ff <= cur_y_ff + DIM_W'(row_h_ff);
            cur_x_ff <= row_x_ff;
            row_h_ff <= '0;
         end
         if (cmd.grow) begin
            grows_ff <= grow_n;
            if (!capped) begin
               row_h_ff <= '0;
               if (to_right) begin
                  row_x_ff <= width_ff;
                  cur_x_ff <= width_ff;
                  cur_y_ff <= '0;
                  width_ff <= {width_ff[DIM_W-2:0], 1'b0};
               end else begin
                  row_x_ff  <= '0;
                  cur_x_ff  <= '0;
                  cur_y_ff  <= height_ff;
                  height_ff <= {height_ff[DIM_W-2:0], 1'b0};
               end
            end
         end
         if (cmd.fail) begin
            failed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         w_ff <= req_tdata[GLYPH_W-1:0];
         h_ff <= req_tdata[2*GLYPH_W-1:GLYPH_W];
      end
      if (cmd.place) begin
         res_placed_ff <= 1'b1;
         res_x_ff <= (cur_x_ff > POS_MAXV) ? POS_W'(POS_MAX) : cur_x_ff[POS_W-1:0];
         res_y_ff <= (cur_y_ff > POS_MAXV) ? POS_W'(POS_MAX) : cur_y_ff[POS_W-1:0];
      end else if (cmd.fail) begin
         res_placed_ff <= 1'b0;
         res_x_ff      <= '0;
         res_y_ff      <= '0;
      end
      if (cmd.load_out) begin
         rsp_tuser_ff <= res_placed_ff;
         rsp_tdata_ff <= {(RSP_DATA_W - 2*POS_W - 2*DIM_W)'(0),
                          height_ff, width_ff, res_y_ff, res_x_ff};
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   `GASP_ASSERT(a_cursor_x_in, clock, reset, cur_x_ff <= width_ff)
   `GASP_ASSERT(a_cursor_y_in, clock, reset, cur_y_ff <= height_ff)
   `GASP_ASSERT(a_place_not_failed, clock, reset, cmd.place |-> !failed_ff)
   `GASP_ASSERT(a_width_range, clock, reset, width_ff >= START_V && width_ff <= CAP_V)

endmodule
`default_nettype wire
